// ----- rtl/srtd_pkg.sv -----
package srtd_pkg;

   // Widths of the transaction fields.
   localparam int CMD_W      = 2;
   localparam int SLOT_W     = 4;
   localparam int FIELD_W    = 16;
   localparam int PRIO_W     = 8;
   localparam int NOW_W      = 32;

   // Command codes carried by a request transaction.
   localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [SLOT_W-1:0]  slot;
      logic [FIELD_W-1:0] arrival_tick;
      logic [FIELD_W-1:0] run_ticks;
      logic [PRIO_W-1:0]  job_priority;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]  running_slot;
      logic               cpu_idle;
      logic               switched;
      logic               job_finished;
      logic [FIELD_W-1:0] remaining_after;
      logic [NOW_W-1:0]   now_tick;
      logic               all_done;
   } rsp_type;

endpackage

// ----- rtl/srtd_ram.sv -----
module srtd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/shortest_remaining_time_dispatch_core.sv -----
// Channel   Direction  Ports                          Moves
// request   in         req_valid, req_stall, req_data one load, tick or clear command
// response  out        rsp_valid, rsp_stall, rsp_data one result per request
//
// A tick transaction passes the scan, write-back and hand-off states between acceptance
// and its registered result: the slot RAM is read one entry per cycle by a single
// comparator. Load, clear and unused commands go straight to the hand-off state; the
// next request can be taken in the cycle after the result is registered.
// Reset is synchronous; slot contents are not cleared, only the valid bits.
// A new request is taken only while the sequencer is idle. A finished result may
// wait on rsp_stall while the next request is already being worked on.
module shortest_remaining_time_dispatch_core
   import srtd_pkg::*;
#(
   parameter int SLOTS     = 16,
   parameter int TICK_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int IDX_W  = $clog2(SLOTS);
   localparam int WORD_W = 2 * TICK_BITS + PRIO_W;

   // Sequencer states.
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_WRITE = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [SLOTS-1:0]     valid_ff, valid_in;
   logic [SLOTS-1:0]     work_ff, work_in;
   logic [NOW_W-1:0]     time_ff, time_in;
   logic [IDX_W-1:0]     last_slot_ff, last_slot_in;
   logic                 last_valid_ff, last_valid_in;

   logic [IDX_W-1:0]     scan_idx_ff, scan_idx_in;
   logic                 issue_ff, issue_in;
   logic [IDX_W-1:0]     rd_idx_ff, rd_idx_in;
   logic                 rd_live_ff, rd_live_in;

   logic                 best_found_ff, best_found_in;
   logic [IDX_W-1:0]     best_idx_ff, best_idx_in;
   logic [TICK_BITS-1:0] best_arr_ff, best_arr_in;
   logic [TICK_BITS-1:0] best_rem_ff, best_rem_in;
   logic [PRIO_W-1:0]    best_prio_ff, best_prio_in;

   rsp_type              pend_ff, pend_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 ram_wr_en;
   logic [IDX_W-1:0]     ram_wr_addr;
   logic [WORD_W-1:0]    ram_wr_data;
   logic [WORD_W-1:0]    ram_rd_data;

   logic [TICK_BITS-1:0] rd_arr, rd_rem, rem_dec;
   logic [PRIO_W-1:0]    rd_prio;
   logic                 eligible, better;
   logic                 req_take, slot_ok;
   logic [IDX_W-1:0]     load_addr;
   logic [TICK_BITS-1:0] load_arr, load_rem;

   // Slot table: arrival, remaining and priority in one word per slot.
   srtd_ram #(
      .WIDTH (WORD_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (scan_idx_ff),
      .rd_data (ram_rd_data)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign load_addr = IDX_W'(req_data.slot);
   assign slot_ok   = (IDX_W + SLOT_W)'(req_data.slot) < (IDX_W + SLOT_W)'(SLOTS);
   assign load_arr  = TICK_BITS'(req_data.arrival_tick);
   assign load_rem  = TICK_BITS'(req_data.run_ticks);

   // Unpack the entry read out of the slot table and compare it with the best so far.
   assign {rd_arr, rd_rem, rd_prio} = ram_rd_data;
   assign eligible = valid_ff[rd_idx_ff] && work_ff[rd_idx_ff]
                     && (NOW_W'(rd_arr) <= time_ff);
   assign better   = !best_found_ff || (rd_rem < best_rem_ff)
                     || ((rd_rem == best_rem_ff) && (rd_prio > best_prio_ff));
   assign rem_dec  = best_rem_ff - TICK_BITS'(1);

   // Sequencer and datapath next-state logic.
   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      work_in       = work_ff;
      time_in       = time_ff;
      last_slot_in  = last_slot_ff;
      last_valid_in = last_valid_ff;
      scan_idx_in   = scan_idx_ff;
      issue_in      = issue_ff;
      rd_idx_in     = scan_idx_ff;
      rd_live_in    = 1'b0;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_arr_in   = best_arr_ff;
      best_rem_in   = best_rem_ff;
      best_prio_in  = best_prio_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = load_addr;
      ram_wr_data   = {load_arr, load_rem, req_data.job_priority};

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               pend_in   = '0;
               state_in  = S_DONE;
               case (req_data.command)
                  CMD_LOAD: begin
                     if (slot_ok) begin
                        ram_wr_en           = 1'b1;
                        valid_in[load_addr] = 1'b1;
                        work_in[load_addr]  = |load_rem;
                     end
                  end
                  CMD_TICK: begin
                     state_in      = S_SCAN;
                     scan_idx_in   = '0;
                     issue_in      = 1'b1;
                     best_found_in = 1'b0;
                  end
                  CMD_CLEAR: begin
                     valid_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_SCAN: begin
            // Issue one read per cycle; judge the entry read in the cycle before.
            rd_live_in = issue_ff;
            if (issue_ff) begin
               if (scan_idx_ff == IDX_W'(SLOTS - 1)) begin
                  issue_in = 1'b0;
               end else begin
                  scan_idx_in = scan_idx_ff + IDX_W'(1);
               end
            end
            if (rd_live_ff && eligible && better) begin
               best_found_in = 1'b1;
               best_idx_in   = rd_idx_ff;
               best_arr_in   = rd_arr;
               best_rem_in   = rd_rem;
               best_prio_in  = rd_prio;
            end
            if (rd_live_ff && !issue_ff) begin
               state_in = S_WRITE;
            end
         end

         S_WRITE: begin
            // Serve the winner, if any, for one tick and advance time unless it is at its top value.
            if (best_found_ff) begin
               ram_wr_en                = 1'b1;
               ram_wr_addr              = best_idx_ff;
               ram_wr_data              = {best_arr_ff, rem_dec, best_prio_ff};
               work_in[best_idx_ff]     = |rem_dec;
               pend_in.running_slot     = SLOT_W'(best_idx_ff);
               pend_in.switched         = !last_valid_ff || (last_slot_ff != best_idx_ff);
               pend_in.job_finished     = ~|rem_dec;
               pend_in.remaining_after  = FIELD_W'(rem_dec);
               last_slot_in             = best_idx_ff;
               last_valid_in            = 1'b1;
            end else begin
               pend_in.cpu_idle = 1'b1;
            end
            if (time_ff != '1) begin
               time_in = time_ff + NOW_W'(1);
            end
            state_in = S_DONE;
         end

         S_DONE: begin
            // Move the result into the output register once it is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in          = pend_ff;
               rsp_in.now_tick = time_ff;
               rsp_in.all_done = ~|(valid_ff & work_ff);
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         time_ff       <= '0;
         last_slot_ff  <= '0;
         last_valid_ff <= 1'b0;
         issue_ff      <= 1'b0;
         rd_live_ff    <= 1'b0;
         best_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         time_ff       <= time_in;
         last_slot_ff  <= last_slot_in;
         last_valid_ff <= last_valid_in;
         issue_ff      <= issue_in;
         rd_live_ff    <= rd_live_in;
         best_found_ff <= best_found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      work_ff      <= work_in;
      scan_idx_ff  <= scan_idx_in;
      rd_idx_ff    <= rd_idx_in;
      best_idx_ff  <= best_idx_in;
      best_arr_ff  <= best_arr_in;
      best_rem_ff  <= best_rem_in;
      best_prio_ff <= best_prio_in;
      pend_ff      <= pend_in;
      rsp_ff       <= rsp_in;
   end

   // A new result appears only out of the hand-off state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result raised outside the hand-off state");

   // An idle tick never reports a switch or a finish.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.cpu_idle) |-> (!rsp_ff.switched && !rsp_ff.job_finished))
      else $error("idle tick reports served-job flags");

   // A finished job leaves nothing remaining.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.job_finished) |-> (rsp_ff.remaining_after == '0))
      else $error("finished job reports remaining work");

   // The write-back state always hands off to the hand-off state in the very next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITE) |=> (state_ff == S_DONE))
      else $error("write-back did not hand off");

endmodule

// ----- dv/shortest_remaining_time_dispatch_core_test.sv -----
`timescale 1ns / 100ps

import srtd_pkg::*;

// Keeps its own copy of the job table and the dispatcher state, works out the
// result of every accepted request, and compares the block's results in order.
class dispatch_scoreboard;
   logic [FIELD_W-1:0] arrival_tbl   [1 << SLOT_W];
   logic [FIELD_W-1:0] remaining_tbl [1 << SLOT_W];
   logic [PRIO_W-1:0]  prio_tbl      [1 << SLOT_W];
   bit                 loaded        [1 << SLOT_W];
   logic [NOW_W-1:0]   now_count;
   logic [SLOT_W-1:0]  last_slot;
   bit                 last_slot_known;
   rsp_type            expected_dispatches [$];

   int mismatches;
   int loads_seen;
   int clears_seen;
   int served_ticks;
   int idle_ticks;
   int switches;
   int finishes;
   int all_done_seen;

   function new();
      foreach (loaded[k]) begin
         loaded[k]        = 1'b0;
         arrival_tbl[k]   = '0;
         remaining_tbl[k] = '0;
         prio_tbl[k]      = '0;
      end
      now_count       = '0;
      last_slot       = '0;
      last_slot_known = 1'b0;
      mismatches      = 0;
      loads_seen      = 0;
      clears_seen     = 0;
      served_ticks    = 0;
      idle_ticks      = 0;
      switches        = 0;
      finishes        = 0;
      all_done_seen   = 0;
   endfunction

   function int pending();
      return expected_dispatches.size();
   endfunction

   // Apply one request to the job table and return what the block must report.
   function rsp_type dispatch_outcome(req_type r);
      rsp_type y;
      int      best;
      y = '0;
      case (r.command)
         CMD_LOAD: begin
            arrival_tbl[r.slot]   = r.arrival_tick;
            remaining_tbl[r.slot] = r.run_ticks;
            prio_tbl[r.slot]      = r.job_priority;
            loaded[r.slot]        = 1'b1;
            loads_seen++;
         end
         CMD_CLEAR: begin
            // Only the valid bits go; time and the last served slot stay.
            foreach (loaded[k]) loaded[k] = 1'b0;
            clears_seen++;
         end
         CMD_TICK: begin
            // Least remaining wins, then the larger priority, then the lower slot.
            best = -1;
            foreach (loaded[k]) begin
               if (loaded[k] && remaining_tbl[k] != '0 &&
                   NOW_W'(arrival_tbl[k]) <= now_count) begin
                  if (best < 0 || remaining_tbl[k] < remaining_tbl[best] ||
                      (remaining_tbl[k] == remaining_tbl[best] &&
                       prio_tbl[k] > prio_tbl[best]))
                     best = k;
               end
            end
            if (best < 0) begin
               y.cpu_idle = 1'b1;
            end else begin
               remaining_tbl[best] = remaining_tbl[best] - FIELD_W'(1);
               y.running_slot      = SLOT_W'(best);
               y.switched          = !last_slot_known || last_slot != y.running_slot;
               y.job_finished      = remaining_tbl[best] == '0;
               y.remaining_after   = remaining_tbl[best];
               last_slot           = y.running_slot;
               last_slot_known     = 1'b1;
            end
            // The time counter sticks at its top value.
            if (now_count != '1) now_count = now_count + NOW_W'(1);
         end
         default: ;
      endcase
      y.now_tick = now_count;
      y.all_done = 1'b1;
      foreach (loaded[k]) begin
         if (loaded[k] && remaining_tbl[k] != '0) y.all_done = 1'b0;
      end
      return y;
   endfunction

   function void note_request(req_type r);
      expected_dispatches.insert(expected_dispatches.size(), dispatch_outcome(r));
   endfunction

   function void compare_field(string name, logic [NOW_W-1:0] want, logic [NOW_W-1:0] got);
      if (got !== want) begin
         $error("%s expected %0d actual %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // Compare one accepted response transaction with the oldest expectation.
   function void check_result(rsp_type got);
      rsp_type want;
      if (expected_dispatches.size() == 0) begin
         $error("response transaction with nothing outstanding: %p", got);
         mismatches++;
         return;
      end
      want = expected_dispatches.pop_front();
      compare_field("running_slot", NOW_W'(want.running_slot), NOW_W'(got.running_slot));
      compare_field("cpu_idle", NOW_W'(want.cpu_idle), NOW_W'(got.cpu_idle));
      compare_field("switched", NOW_W'(want.switched), NOW_W'(got.switched));
      compare_field("job_finished", NOW_W'(want.job_finished), NOW_W'(got.job_finished));
      compare_field("remaining_after", NOW_W'(want.remaining_after),
                    NOW_W'(got.remaining_after));
      compare_field("now_tick", want.now_tick, got.now_tick);
      compare_field("all_done", NOW_W'(want.all_done), NOW_W'(got.all_done));
      if (want.cpu_idle) idle_ticks++;
      if (want.switched) switches++;
      if (want.job_finished) finishes++;
      if (want.all_done) all_done_seen++;
      if (want.switched || want.job_finished || want.remaining_after != '0)
         served_ticks++;
   endfunction
endclass

module shortest_remaining_time_dispatch_core_test;
   localparam int SLOT_COUNT       = 16;
   localparam int TICK_WIDTH       = 16;
   localparam int RANDOM_ITEMS     = 1700;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES    = 3 * (SLOT_COUNT + 3);
   localparam int CYCLE_LIMIT      = 400000;

   // Code the block does not use; it must report it like a load and change nothing.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   dispatch_scoreboard dispatch_check;
   bit sender_bursts     = 1'b0;
   bit receiver_bursts   = 1'b0;
   bit long_hold_request = 1'b0;
   int items_sent        = 0;
   int ticks_sent        = 0;
   int cycle_count       = 0;

   shortest_remaining_time_dispatch_core #(
      .SLOTS     (SLOT_COUNT),
      .TICK_BITS (TICK_WIDTH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog, and the monitor that feeds both handshakes to the scoreboard.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else if (!reset) begin
         if (req_valid && !req_stall) dispatch_check.note_request(req_data);
         if (rsp_valid && !rsp_stall) dispatch_check.check_result(rsp_data);
      end
   end

   // Result side: short random stalls, and one long hold when asked for.
   initial begin : receiver
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (receiver_bursts && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic req_type job_request(logic [CMD_W-1:0] cmd, int slot, int arrival,
                                           int run, int prio);
      req_type r;
      r.command      = cmd;
      r.slot         = SLOT_W'(slot);
      r.arrival_tick = FIELD_W'(arrival);
      r.run_ticks    = FIELD_W'(run);
      r.job_priority = PRIO_W'(prio);
      return r;
   endfunction

   function automatic req_type random_request(logic [CMD_W-1:0] cmd);
      return job_request(cmd, $urandom, $urandom, $urandom, $urandom);
   endfunction

   // Offer one request transaction and hold it until the block takes it.
   task automatic send_request(input req_type r);
      if (sender_bursts && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      items_sent++;
      if (r.command == CMD_TICK) ticks_sent++;
   endtask

   // Stop offering until every outstanding result has come back.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (dispatch_check.pending() != 0);
   endtask

   // One batch of jobs: maybe a clear, a few loads around the current time, then ticks with an occasional unused code.
   task automatic run_job_batch();
      req_type r;
      int      loads;
      int      ticks;
      loads = $urandom_range(1, 6);
      ticks = $urandom_range(1, 24);
      if ($urandom_range(0, 4) == 0) send_request(random_request(CMD_CLEAR));
      repeat (loads) begin
         r = random_request(CMD_LOAD);
         // Most jobs arrive soon after now or have already arrived; the rest keep a full-range arrival.
         if ($urandom_range(0, 7) != 0) begin
            if ($urandom_range(0, 1) == 0)
               r.arrival_tick = FIELD_W'(ticks_sent + $urandom_range(0, 12));
            else
               r.arrival_tick = FIELD_W'($urandom_range(0, ticks_sent));
         end
         case ($urandom_range(0, 15))
            0: r.run_ticks = '0;
            1: ;
            default: r.run_ticks = FIELD_W'($urandom_range(1, 10));
         endcase
         // Cluster priorities so ties on both keys come up often.
         if ($urandom_range(0, 1) == 0)
            r.job_priority = ($urandom_range(0, 1) == 0) ? {PRIO_W{1'b0}} : {PRIO_W{1'b1}};
         send_request(r);
      end
      repeat (ticks) begin
         if ($urandom_range(0, 19) == 0) send_request(random_request(CMD_UNUSED));
         send_request(random_request(CMD_TICK));
      end
   endtask

   initial begin : stimulus
      int first_random;
      int batch;
      dispatch_check = new();
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      sender_bursts   = 1'b1;
      receiver_bursts = 1'b1;

      // Directed: empty-table tick, the unused code, tie breaks, a job that never
      // arrives, preemption by a shorter job, a zero-length job, and a clear that
      // keeps the last served slot.
      send_request(job_request(CMD_TICK, 0, 0, 0, 0));
      send_request(job_request(CMD_UNUSED, 15, 65535, 65535, 255));
      send_request(job_request(CMD_CLEAR, 0, 0, 0, 0));
      send_request(job_request(CMD_LOAD, 0, 0, 3, 0));
      send_request(job_request(CMD_LOAD, 15, 0, 3, 255));
      send_request(job_request(CMD_LOAD, 7, 0, 3, 255));
      send_request(job_request(CMD_LOAD, 3, 65535, 65535, 128));
      repeat (4) send_request(job_request(CMD_TICK, 0, 0, 0, 0));
      send_request(job_request(CMD_LOAD, 9, 0, 1, 0));
      repeat (3) send_request(job_request(CMD_TICK, 0, 0, 0, 0));
      send_request(job_request(CMD_LOAD, 5, 0, 0, 10));
      repeat (2) send_request(job_request(CMD_TICK, 0, 0, 0, 0));
      send_request(job_request(CMD_CLEAR, 0, 0, 0, 0));
      send_request(job_request(CMD_TICK, 0, 0, 0, 0));
      send_request(job_request(CMD_LOAD, 0, 0, 2, 1));
      repeat (2) send_request(job_request(CMD_TICK, 0, 0, 0, 0));

      // Random batches; the last fifth runs with no idling on either side.
      first_random = items_sent;
      batch        = 0;
      while (items_sent - first_random < RANDOM_ITEMS) begin
         if (items_sent - first_random > RANDOM_ITEMS * 4 / 5) begin
            sender_bursts   = 1'b0;
            receiver_bursts = 1'b0;
         end else begin
            sender_bursts   = (batch % 8) != 3;
            receiver_bursts = (batch % 8) != 5;
         end
         if (batch == 20) long_hold_request = 1'b1;
         if (batch == 45) wait_for_results();
         run_job_batch();
         batch++;
      end

      req_valid <= 1'b0;
      while (dispatch_check.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Run covered %0d requests: %0d loads, %0d clears, %0d ticks (%0d idle).",
               items_sent, dispatch_check.loads_seen, dispatch_check.clears_seen,
               ticks_sent, dispatch_check.idle_ticks);
      $display("Jobs served %0d ticks with %0d switches, %0d finishes, all done seen %0d times.",
               dispatch_check.served_ticks, dispatch_check.switches,
               dispatch_check.finishes, dispatch_check.all_done_seen);
      if (dispatch_check.mismatches == 0 && dispatch_check.pending() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule
